// ----- rtl/waveform_frame_peak_baseline_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the waveform frame peak/baseline block
// Property wrappers that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef WAVEFORM_FRAME_PEAK_BASELINE_ASSERT_SVH
`define WAVEFORM_FRAME_PEAK_BASELINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define WFPB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfpb assertion failed");
// next-cycle implication
`define WFPB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfpb assertion failed");
`else
`define WFPB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WFPB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/wfpb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfpb_pkg
// Shared constants, types and command/status bundles for the frame
// peak/baseline extractor.
// ---------------------------------------------------------------------------
package wfpb_pkg;

  localparam int NUM_CHANNELS        = 26;
  localparam int SAMPLES_PER_CHANNEL = 128;
  // baseline window is a power of two so the average is a plain shift
  localparam int BASELINE_SHIFT      = 4;
  localparam int BASELINE_SAMPLES    = 1 << BASELINE_SHIFT;

  localparam int HEADER_BYTES = 10;
  localparam int BOARD_BYTE   = 7;
  localparam int TRAILER_POS  = 6660;
  localparam int PAYLOAD_LAST = 6661;

  localparam int STRIDE = 2 * SAMPLES_PER_CHANNEL;
  localparam int WIN_W  = $clog2(STRIDE);
  localparam int SMP_W  = WIN_W - 1;
  localparam int CHC_W  = $clog2(NUM_CHANNELS + 1);
  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W  = 13;
  localparam int HDR_W  = 4;

  localparam int DATA_W  = 8;
  localparam int FEE_W   = 4;
  localparam int CHAN_W  = 5;
  localparam int SAMP_W  = 16;
  localparam int SUM_W   = 20;
  localparam int PKT_W   = 2;
  localparam int EVT_W   = 32;
  localparam int OUT_W   = FEE_W + CHAN_W + SAMP_W + SAMP_W + PKT_W + EVT_W;
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [DATA_W-1:0] SYNC_WORD [4] = '{8'h55, 8'hAA, 8'hEB, 8'h90};
  localparam logic [DATA_W-1:0] TRAILER_0 = 8'h5A;
  localparam logic [DATA_W-1:0] TRAILER_1 = 8'hA5;
  localparam logic [PKT_W-1:0]  PKT_LAST  = 2'd3;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HEADER,
    ST_PAYLOAD,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic hunt_acc;   // byte taken while searching for sync
    logic hdr_acc;    // byte taken in header
    logic pay_acc;    // byte taken in payload
    logic ro_load;    // load output register from readout data
    logic ro_next;    // step readout index
    logic ro_finish;  // frame readout complete, bump counters
  } cmd_t;

  typedef struct packed {
    logic sync_found;
    logic hdr_last;
    logic frame_end;
    logic trailer_good;
    logic ro_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/wfpb_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfpb_ctrl
// Frame sequencer: sync hunt, header, payload, and per-channel readout.
// ---------------------------------------------------------------------------
module wfpb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  wfpb_pkg::status_t status,
  output wfpb_pkg::cmd_t   cmd
);
  import wfpb_pkg::*;

  state_t state;
  state_t state_next;
  logic   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    acc        = 1'b0;
    unique case (state)
      ST_HUNT: begin
        s_tready     = 1'b1;
        acc          = s_tvalid;
        cmd.hunt_acc = acc;
        if (acc && status.sync_found) begin
          state_next = ST_HEADER;
        end
      end
      ST_HEADER: begin
        s_tready    = 1'b1;
        acc         = s_tvalid;
        cmd.hdr_acc = acc;
        if (acc && status.hdr_last) begin
          state_next = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        s_tready    = 1'b1;
        acc         = s_tvalid;
        cmd.pay_acc = acc;
        if (acc && status.frame_end) begin
          state_next = status.trailer_good ? ST_READ : ST_HUNT;
        end
      end
      ST_READ: begin
        // memory read data is valid in the next cycle
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.ro_load = 1'b1;
          if (status.ro_last) begin
            cmd.ro_finish = 1'b1;
            state_next    = ST_HUNT;
          end else begin
            cmd.ro_next = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
    // no transactions while in reset
    if (rst) begin
      s_tready = 1'b0;
    end
  end

endmodule

// ----- rtl/wfpb_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfpb_dp
// Byte datapath: sync compare, header capture, sample assembly, per-channel
// peak/sum accumulation, channel store and output register.
// ---------------------------------------------------------------------------
module wfpb_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [wfpb_pkg::DATA_W-1:0]        byte_in,
  input  wfpb_pkg::cmd_t                     cmd,
  output wfpb_pkg::status_t                  status,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [wfpb_pkg::TDATA_W-1:0]       m_tdata,
  output logic                               m_tlast
);
  import wfpb_pkg::*;

  logic [1:0]        sync_match;
  logic [HDR_W-1:0]  hdr_cnt;
  logic [FEE_W-1:0]  board_id;
  logic [POS_W-1:0]  pos;
  logic [WIN_W-1:0]  win_pos;
  logic [CHC_W-1:0]  ch;
  logic [DATA_W-1:0] sample_high;
  logic              trailer_ok;
  logic [SAMP_W-1:0] cur_peak;
  logic [SUM_W-1:0]  cur_sum;
  logic [IDX_W-1:0]  ro_idx;
  logic [PKT_W-1:0]  pkt_cnt;
  logic [EVT_W-1:0]  evt_cnt;

  logic [SAMP_W+SUM_W-1:0] chan_mem [NUM_CHANNELS];
  logic [SAMP_W+SUM_W-1:0] rd_data;

  logic [FEE_W-1:0]  o_fee;
  logic [CHAN_W-1:0] o_chan;
  logic [SAMP_W-1:0] o_peak;
  logic [SAMP_W-1:0] o_base;
  logic [PKT_W-1:0]  o_pkt;
  logic [EVT_W-1:0]  o_evt;

  logic              in_data;
  logic              ch_active;
  logic [SMP_W-1:0]  smp_idx;
  logic [SAMP_W-1:0] sample;
  logic [SAMP_W-1:0] peak_next;
  logic [SUM_W-1:0]  sum_next;
  logic              odd_take;
  logic              mem_we;
  logic [FEE_W-1:0]  nib;

  assign ch_active = (ch < CHC_W'(NUM_CHANNELS));
  assign in_data   = (pos < POS_W'(TRAILER_POS)) && ch_active;
  assign smp_idx   = win_pos[WIN_W-1:1];
  assign sample    = {sample_high, byte_in};
  assign odd_take  = cmd.pay_acc && in_data && win_pos[0];
  assign mem_we    = odd_take && (smp_idx == SMP_W'(SAMPLES_PER_CHANNEL - 1));
  assign nib       = byte_in[7:4];

  always_comb begin
    if (smp_idx == '0) begin
      peak_next = sample;
      sum_next  = SUM_W'(sample);
    end else begin
      peak_next = (sample > cur_peak) ? sample : cur_peak;
      sum_next  = (smp_idx < SMP_W'(BASELINE_SAMPLES)) ? cur_sum + SUM_W'(sample) : cur_sum;
    end
  end

  always_comb begin
    status.sync_found   = (sync_match == 2'd3) && (byte_in == SYNC_WORD[3]);
    status.hdr_last     = (hdr_cnt == HDR_W'(HEADER_BYTES - 1));
    status.frame_end    = (pos == POS_W'(PAYLOAD_LAST));
    status.trailer_good = trailer_ok && (byte_in == TRAILER_1);
    status.ro_last      = (ro_idx == IDX_W'(NUM_CHANNELS - 1));
    status.out_free     = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_match  <= '0;
      hdr_cnt     <= '0;
      board_id    <= '0;
      pos         <= '0;
      win_pos     <= '0;
      ch          <= '0;
      sample_high <= '0;
      trailer_ok  <= 1'b0;
      ro_idx      <= '0;
      pkt_cnt     <= '0;
      evt_cnt     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // overlapping sync search: a mismatch may start a new match
      if (cmd.hunt_acc) begin
        if (byte_in == SYNC_WORD[sync_match]) begin
          sync_match <= sync_match + 2'd1;
          if (sync_match == 2'd3) begin
            hdr_cnt <= '0;
          end
        end else begin
          sync_match <= (byte_in == SYNC_WORD[0]) ? 2'd1 : 2'd0;
        end
      end

      if (cmd.hdr_acc) begin
        hdr_cnt <= hdr_cnt + HDR_W'(1);
        if (hdr_cnt == HDR_W'(BOARD_BYTE)) begin
          board_id <= (nib > FEE_W'(4)) ? nib - FEE_W'(4) : nib;
        end
        if (status.hdr_last) begin
          pos     <= '0;
          win_pos <= '0;
          ch      <= '0;
        end
      end

      if (cmd.pay_acc) begin
        pos <= pos + POS_W'(1);
        if (pos == POS_W'(TRAILER_POS)) begin
          trailer_ok <= (byte_in == TRAILER_0);
        end
        if (status.frame_end) begin
          ro_idx <= '0;
        end
        if (in_data) begin
          if (!win_pos[0]) begin
            sample_high <= byte_in;
          end
          if (win_pos == WIN_W'(STRIDE - 1)) begin
            win_pos <= '0;
            ch      <= ch + CHC_W'(1);
          end else begin
            win_pos <= win_pos + WIN_W'(1);
          end
        end
      end

      if (cmd.ro_next) begin
        ro_idx <= ro_idx + IDX_W'(1);
      end

      if (cmd.ro_finish) begin
        if (pkt_cnt == PKT_LAST) begin
          pkt_cnt <= '0;
          evt_cnt <= evt_cnt + EVT_W'(1);
        end else begin
          pkt_cnt <= pkt_cnt + PKT_W'(1);
        end
      end

      if (cmd.ro_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (odd_take) begin
      cur_peak <= peak_next;
      cur_sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      chan_mem[ch[IDX_W-1:0]] <= {peak_next, sum_next};
    end
    rd_data <= chan_mem[ro_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.ro_load) begin
      o_fee   <= board_id;
      o_chan  <= CHAN_W'(ro_idx);
      o_peak  <= rd_data[SAMP_W+SUM_W-1:SUM_W];
      o_base  <= rd_data[BASELINE_SHIFT +: SAMP_W];
      o_pkt   <= pkt_cnt;
      o_evt   <= evt_cnt;
      m_tlast <= status.ro_last;
    end
  end

  assign m_tdata = {{(TDATA_W - OUT_W){1'b0}}, o_evt, o_pkt, o_base, o_peak, o_chan, o_fee};

endmodule

// ----- rtl/waveform_frame_peak_baseline.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// waveform_frame_peak_baseline
// Frame parser that reports per-channel peak and baseline of waveforms.
// ---------------------------------------------------------------------------
// Input channel s_*: one raw stream byte per transaction. The block hunts for
// the sync word 55 AA EB 90, takes a 10-byte header and a 6662-byte payload,
// and accumulates peak and 16-sample baseline for each channel on the fly.
// Output channel m_*: one transaction per channel when the frame trailer is
// good, m_tlast on the final channel. A bad trailer gives no output.
// Throughput: one input byte per cycle while parsing. After the last byte of
// a good frame, s_tready drops for the readout: each result takes a
// channel-store read, then the output register load, and the first result
// is presented once that load has registered. A stalled receiver holds
// the current result and halts the readout; one finished result may wait
// while input bytes are taken.
// Reset (rst, synchronous) returns to sync search and clears the packet and
// event counters; the channel store is not cleared, every entry is written
// by a frame before it is read out.
// ---------------------------------------------------------------------------
module waveform_frame_peak_baseline (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [7:0] data_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [3:0] fee_id, [8:4] channel, [24:9] peak, [40:25] baseline,
  // [42:41] packet_in_event, [74:43] event_number, [79:75] zero
  output logic [wfpb_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast   // last_channel
);
  import wfpb_pkg::*;

  cmd_t    cmd;
  status_t status;

  wfpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wfpb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`include "waveform_frame_peak_baseline_assert.svh"

  // input is held off whenever a result is loaded in the readout
  `WFPB_ASSERT_IMP(a_no_input_in_readout, clk, rst, cmd.ro_load, !s_tready)
  // a loaded result is presented next cycle
  `WFPB_ASSERT_NXT(a_load_presents, clk, rst, cmd.ro_load, m_tvalid)
  // tlast marks exactly the final channel
  `WFPB_ASSERT_IMP(a_last_channel, clk, rst, m_tvalid,
    m_tlast == (m_tdata[8:4] == CHAN_W'(NUM_CHANNELS - 1)))

endmodule

// ----- tb/sv/waveform_frame_peak_baseline_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// waveform_frame_peak_baseline_tb
// Drives framed detector byte streams (sync hunt, header, channel waveforms,
// trailer) with random gaps and receiver stalls. A byte-level tracker works
// out the per-channel peak/baseline reports, which are compared field by
// field with each output transaction.
// ---------------------------------------------------------------------------
module waveform_frame_peak_baseline_tb;
  import wfpb_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int IDLE_PCT     = 34;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * NUM_CHANNELS + 20;
  localparam int FRAME_BYTES  = HEADER_BYTES + PAYLOAD_LAST + 1;
  localparam int FILL_BYTES   = TRAILER_POS - NUM_CHANNELS * STRIDE;
  localparam int MAX_PRINTS   = 100;
  localparam int RANDOM_REPORTS = 104;
  localparam logic [31:0] SYNC_SEQ = 32'h55AAEB90;

  typedef enum {PAT_ZERO, PAT_FULL, PAT_SYNC, PAT_MIXED} wave_pattern_t;
  typedef enum {WAVE_NOISE, WAVE_SPIKE, WAVE_FLAT, WAVE_DECAY} chan_shape_t;

  typedef struct packed {
    logic [FEE_W-1:0]  fee;
    logic [CHAN_W-1:0] chan;
    logic [SAMP_W-1:0] peak;
    logic [SAMP_W-1:0] base;
    logic [PKT_W-1:0]  pkt;
    logic [EVT_W-1:0]  evt;
    logic              last;
  } chan_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;

  bit full_rate = 1'b0;
  int errors = 0;
  int reports_predicted = 0;
  int cycle_count = 0;

  // tracker state
  logic [1:0]        sync_cnt = '0;
  logic              framing = 1'b0;
  int                byte_idx = 0;
  logic [FEE_W-1:0]  fee_nib = '0;
  logic [7:0]        hi_byte = '0;
  logic              tr0_ok = 1'b0;
  logic [SAMP_W-1:0] peak_mem [NUM_CHANNELS];
  logic [SUM_W-1:0]  sum_mem  [NUM_CHANNELS];
  logic [PKT_W-1:0]  pkt_cnt = '0;
  logic [EVT_W-1:0]  evt_cnt = '0;

  chan_report_t pending_reports [$];

  waveform_frame_peak_baseline DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] sync_byte(input int i);
    return SYNC_SEQ[8 * (3 - i) +: 8];
  endfunction

  // Byte-level model of the parser; queues the reports of a good frame.
  function automatic void parse_stream_byte(input logic [7:0] b);
    int pos;
    int ch;
    int win_pos;
    int s;
    logic [SAMP_W-1:0] v;
    chan_report_t rec;
    if (!framing) begin
      if (b == sync_byte(int'(sync_cnt))) begin
        if (sync_cnt == 2'd3) begin
          sync_cnt = '0;
          framing = 1'b1;
          byte_idx = 0;
        end else begin
          sync_cnt = sync_cnt + 2'd1;
        end
      end else begin
        // a failed byte may itself open a new sync word
        sync_cnt = (b == sync_byte(0)) ? 2'd1 : 2'd0;
      end
      return;
    end
    if (byte_idx < HEADER_BYTES) begin
      if (byte_idx == BOARD_BYTE)
        fee_nib = (b[7:4] > 4'd4) ? b[7:4] - 4'd4 : b[7:4];
    end else begin
      pos = byte_idx - HEADER_BYTES;
      if (pos == TRAILER_POS) begin
        tr0_ok = (b == TRAILER_0);
      end else if (pos == TRAILER_POS + 1) begin
        if (tr0_ok && b == TRAILER_1) begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            rec.fee  = fee_nib;
            rec.chan = CHAN_W'(c);
            rec.peak = peak_mem[c];
            rec.base = SAMP_W'(sum_mem[c] / BASELINE_SAMPLES);
            rec.pkt  = pkt_cnt;
            rec.evt  = evt_cnt;
            rec.last = (c == NUM_CHANNELS - 1);
            pending_reports.push_back(rec);
          end
          reports_predicted += NUM_CHANNELS;
          if (pkt_cnt == PKT_LAST) begin
            pkt_cnt = '0;
            evt_cnt = evt_cnt + 1;
          end else begin
            pkt_cnt = pkt_cnt + 1'b1;
          end
        end
      end else if (pos < TRAILER_POS) begin
        ch = pos / STRIDE;
        win_pos = pos % STRIDE;
        s = win_pos >> 1;
        if (ch < NUM_CHANNELS) begin
          if (win_pos % 2 == 0) begin
            hi_byte = b;
          end else begin
            v = {hi_byte, b};
            if (s == 0) begin
              peak_mem[ch] = v;
              sum_mem[ch] = SUM_W'(v);
            end else begin
              if (v > peak_mem[ch])
                peak_mem[ch] = v;
              if (s < BASELINE_SAMPLES)
                sum_mem[ch] = sum_mem[ch] + SUM_W'(v);
            end
          end
        end
      end
    end
    byte_idx++;
    if (byte_idx >= FRAME_BYTES) begin
      framing = 1'b0;
      byte_idx = 0;
      sync_cnt = '0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int chan, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got)
      report_mismatch($sformatf("channel %0d %s: expected %0h, got %0h", chan, name, want,
                                got));
  endtask

  task automatic check_report();
    chan_report_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction, tdata %h", m_tdata));
      return;
    end
    want = pending_reports.pop_front();
    check_field("fee_id", int'(want.chan), 32'(want.fee), 32'(m_tdata[3:0]));
    check_field("channel", int'(want.chan), 32'(want.chan), 32'(m_tdata[8:4]));
    check_field("peak", int'(want.chan), 32'(want.peak), 32'(m_tdata[24:9]));
    check_field("baseline", int'(want.chan), 32'(want.base), 32'(m_tdata[40:25]));
    check_field("packet_in_event", int'(want.chan), 32'(want.pkt), 32'(m_tdata[42:41]));
    check_field("event_number", int'(want.chan), want.evt, m_tdata[74:43]);
    check_field("last_channel", int'(want.chan), 32'(want.last), 32'(m_tlast));
  endtask

  // receiver side: check on each accepted transaction, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_report();
    m_tready <= full_rate || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!full_rate && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    parse_stream_byte(b);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom));
  endtask

  function automatic logic [15:0] wave_sample(input wave_pattern_t pat, input chan_shape_t shape,
                                              input int s, input int spike_at,
                                              input logic [15:0] level);
    case (pat)
      PAT_ZERO: return 16'h0000;
      PAT_FULL: return 16'hFFFF;
      PAT_SYNC: begin
        // sync and trailer words buried in the payload
        case (s % 3)
          0:       return {sync_byte(0), sync_byte(1)};
          1:       return {sync_byte(2), sync_byte(3)};
          default: return {TRAILER_0, TRAILER_1};
        endcase
      end
      default: begin
        case (shape)
          WAVE_NOISE: return 16'($urandom);
          WAVE_SPIKE: return (s == spike_at) ? (level | 16'h8000) : 16'($urandom_range(0, 255));
          WAVE_FLAT:  return level;
          default:    return level - 16'(s);
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(input logic [3:0] nib, input wave_pattern_t pat,
                            input logic [7:0] tr0, input logic [7:0] tr1);
    logic [15:0] v;
    logic [15:0] level;
    chan_shape_t shape;
    int spike_at;
    for (int i = 0; i < 4; i++)
      send_byte(sync_byte(i));
    for (int h = 0; h < HEADER_BYTES; h++)
      send_byte((h == BOARD_BYTE) ? {nib, 4'($urandom)} : 8'($urandom));
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      shape = chan_shape_t'($urandom_range(0, 3));
      level = 16'($urandom);
      case ($urandom_range(0, 2))
        0:       spike_at = 0;
        1:       spike_at = SAMPLES_PER_CHANNEL - 1;
        default: spike_at = $urandom_range(0, SAMPLES_PER_CHANNEL - 1);
      endcase
      for (int s = 0; s < SAMPLES_PER_CHANNEL; s++) begin
        v = wave_sample(pat, shape, s, spike_at, level);
        send_byte(v[15:8]);
        send_byte(v[7:0]);
      end
    end
    send_noise(FILL_BYTES);
    send_byte(tr0);
    send_byte(tr1);
  endtask

  task automatic test_sync_hunt();
    // repeated and broken sync starts, then a frame right behind a partial match
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sync_byte(0));
    send_byte(sync_byte(0));
    send_byte(sync_byte(1));
    send_byte(sync_byte(2));
    send_byte(sync_byte(0));
    send_byte(sync_byte(1));
    send_byte(sync_byte(0));
    send_byte(8'h00);
    send_byte(sync_byte(0));
    send_byte(sync_byte(1));
    send_byte(sync_byte(2));
    send_frame(4'h0, PAT_ZERO, TRAILER_0, TRAILER_1);
  endtask

  task automatic test_sample_extremes();
    // full-rate stretch on both sides
    full_rate = 1'b1;
    send_frame(4'hF, PAT_FULL, TRAILER_0, TRAILER_1);
    full_rate = 1'b0;
    send_frame(4'h4, PAT_MIXED, TRAILER_0, TRAILER_1);
    send_frame(4'h5, PAT_MIXED, TRAILER_0, TRAILER_1);
  endtask

  task automatic test_sync_in_payload();
    send_frame(4'h3, PAT_SYNC, TRAILER_0, TRAILER_1);
  endtask

  task automatic test_bad_trailer();
    send_frame(4'h9, PAT_MIXED, TRAILER_0, 8'h00);
    send_frame(4'h1, PAT_MIXED, 8'h00, TRAILER_1);
    send_frame(4'h2, PAT_MIXED, TRAILER_1, TRAILER_0);
    // counters must not have moved
    send_frame(4'h7, PAT_MIXED, TRAILER_0, TRAILER_1);
  endtask

  task automatic test_random_frames();
    int start;
    int k;
    wave_pattern_t pat;
    start = reports_predicted;
    while (reports_predicted - start < RANDOM_REPORTS) begin
      if ($urandom_range(0, 3) != 0)
        send_noise($urandom_range(0, 6));
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          send_byte(sync_byte(i));
        send_noise(1);
      end
      pat = ($urandom_range(0, 99) < 85) ? PAT_MIXED : wave_pattern_t'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0)
        send_frame(4'($urandom), pat, 8'($urandom), 8'($urandom));
      else
        send_frame(4'($urandom), pat, TRAILER_0, TRAILER_1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sync_hunt();
    test_sample_extremes();
    test_sync_in_payload();
    test_bad_trailer();
    test_random_frames();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
